@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the valve motor sequencer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/vms_pkg.sv @@
// ----------------------------------------------------------------------------
// vms_pkg
// Types, codes and helpers of the valve motor sequencer.
// ----------------------------------------------------------------------------
package vms_pkg;

   localparam int TICK_W = 16;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   // reset values of the timing registers
   localparam logic [TICK_W-1:0] FULL_TRAVEL_RST = 16'd10000;
   localparam logic [TICK_W-1:0] HALF_OPEN_RST = 16'd5000;
   localparam logic [TICK_W-1:0] HALF_CLOSE_RST = 16'd5000;
   localparam logic [TICK_W-1:0] GUARD_RST = 16'd20000;

   // item kinds
   typedef enum logic [2:0] {
      CMD_COMMAND     = 3'd0,
      CMD_TICK        = 3'd1,
      CMD_OPEN_HIT    = 3'd2,
      CMD_CLOSE_HIT   = 3'd3,
      CMD_OVERCURRENT = 3'd4
   } cmd_type;

   // valve requests
   typedef enum logic [2:0] {
      REQ_IDLE       = 3'd0,
      REQ_FULL_OPEN  = 3'd1,
      REQ_HALF_OPEN  = 3'd2,
      REQ_FULL_CLOSE = 3'd3,
      REQ_MAINTAIN   = 3'd4
   } req_type;

   // moves held by the sequencer
   typedef enum logic [1:0] {
      MV_IDLE       = 2'd0,
      MV_FULL_OPEN  = 2'd1,
      MV_HALF       = 2'd2,
      MV_FULL_CLOSE = 2'd3
   } move_type;

   // valve position
   typedef enum logic [1:0] {
      POS_OPEN  = 2'd0,
      POS_HALF  = 2'd1,
      POS_CLOSE = 2'd2,
      POS_OCP   = 2'd3
   } pos_type;

   // register indexes (byte address bits [3:2])
   typedef enum logic [1:0] {
      REG_FULL_TRAVEL = 2'd0,
      REG_HALF_OPEN   = 2'd1,
      REG_HALF_CLOSE  = 2'd2,
      REG_GUARD       = 2'd3
   } reg_idx_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic [2:0] request;
      logic       open_limit_n;
      logic       close_limit_n;
   } req_item_type;

   typedef struct packed {
      logic       motor_on;
      logic       motor_ccw;
      logic [1:0] valve_position;
      logic       awake;
   } rsp_item_type;

   typedef struct packed {
      logic [TICK_W-1:0] full_travel_ticks;
      logic [TICK_W-1:0] half_from_open_ticks;
      logic [TICK_W-1:0] half_from_close_ticks;
      logic [TICK_W-1:0] guard_ticks;
   } cfg_type;

   // limit switch sampling; overcurrent is sticky
   function automatic pos_type sample_pos(pos_type pos, logic open_n, logic close_n);
      pos_type res;
      if (pos == POS_OCP) begin
         res = POS_OCP;
      end else if (!open_n) begin
         res = POS_OPEN;
      end else if (!close_n) begin
         res = POS_CLOSE;
      end else begin
         res = POS_HALF;
      end
      return res;
   endfunction

endpackage

@@ rtl/vms_csr.sv @@
// ----------------------------------------------------------------------------
// vms_csr
// Timing registers behind the APB-style configuration port.
// ----------------------------------------------------------------------------
module vms_csr
   import vms_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   logic        wr_en;
   reg_idx_type idx;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel & csr_penable & csr_pwrite;
   assign idx = reg_idx_type'(csr_paddr[3:2]);

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_FULL_TRAVEL: cfg_in.full_travel_ticks = csr_pwdata[TICK_W-1:0];
            REG_HALF_OPEN:   cfg_in.half_from_open_ticks = csr_pwdata[TICK_W-1:0];
            REG_HALF_CLOSE:  cfg_in.half_from_close_ticks = csr_pwdata[TICK_W-1:0];
            REG_GUARD:       cfg_in.guard_ticks = csr_pwdata[TICK_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.full_travel_ticks <= FULL_TRAVEL_RST;
         cfg_ff.half_from_open_ticks <= HALF_OPEN_RST;
         cfg_ff.half_from_close_ticks <= HALF_CLOSE_RST;
         cfg_ff.guard_ticks <= GUARD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      csr_prdata = '0;
      unique case (idx)
         REG_FULL_TRAVEL: csr_prdata[TICK_W-1:0] = cfg_ff.full_travel_ticks;
         REG_HALF_OPEN:   csr_prdata[TICK_W-1:0] = cfg_ff.half_from_open_ticks;
         REG_HALF_CLOSE:  csr_prdata[TICK_W-1:0] = cfg_ff.half_from_close_ticks;
         REG_GUARD:       csr_prdata[TICK_W-1:0] = cfg_ff.guard_ticks;
         default:         csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/vms_core.sv @@
// ----------------------------------------------------------------------------
// vms_core
// Sequencer state, move and guard timers, and the next-state logic for one
// request per cycle in which step is high.
// ----------------------------------------------------------------------------
module vms_core
   import vms_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  req_item_type item,
   input  cfg_type      cfg,
   output rsp_item_type result
);

   pos_type           pos_ff, pos_in;
   move_type          cur_ff, cur_in;
   move_type          que_ff, que_in;
   logic              on_ff, on_in;
   logic              ccw_ff, ccw_in;
   logic [TICK_W-1:0] mcnt_ff, mcnt_in;
   logic              mrun_ff, mrun_in;
   logic [TICK_W-1:0] gcnt_ff, gcnt_in;
   logic              act_ff, act_in;

   pos_type           sampled;
   logic              stop_en;
   logic              start_en;
   logic              start_ccw;
   logic [TICK_W-1:0] start_ticks;
   move_type          start_now;
   move_type          start_next;

   assign sampled = sample_pos(pos_ff, item.open_limit_n, item.close_limit_n);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= POS_HALF;
         cur_ff  <= MV_IDLE;
         que_ff  <= MV_IDLE;
         on_ff   <= 1'b0;
         ccw_ff  <= 1'b0;
         mcnt_ff <= '0;
         mrun_ff <= 1'b0;
         gcnt_ff <= '0;
         act_ff  <= 1'b0;
      end else if (step) begin
         pos_ff  <= pos_in;
         cur_ff  <= cur_in;
         que_ff  <= que_in;
         on_ff   <= on_in;
         ccw_ff  <= ccw_in;
         mcnt_ff <= mcnt_in;
         mrun_ff <= mrun_in;
         gcnt_ff <= gcnt_in;
         act_ff  <= act_in;
      end
   end

   // next state: pick a move start and/or a stop, then apply them
   always_comb begin
      pos_in = pos_ff;
      cur_in = cur_ff;
      que_in = que_ff;
      on_in = on_ff;
      ccw_in = ccw_ff;
      mcnt_in = mcnt_ff;
      mrun_in = mrun_ff;
      gcnt_in = gcnt_ff;
      act_in = act_ff;
      stop_en = 1'b0;
      start_en = 1'b0;
      start_ccw = 1'b0;
      start_ticks = cfg.full_travel_ticks;
      start_now = MV_IDLE;
      start_next = MV_IDLE;

      unique case (item.cmd)
         CMD_COMMAND: begin
            act_in = 1'b1;
            gcnt_in = cfg.guard_ticks;
            pos_in = sampled;
            unique case (item.request)
               REQ_FULL_OPEN: begin
                  if (sampled == POS_OPEN) begin
                     stop_en = 1'b1;
                  end else begin
                     start_en = 1'b1;
                     start_now = MV_FULL_OPEN;
                  end
               end
               REQ_HALF_OPEN: begin
                  // at overcurrent only the guard restarts
                  if (sampled == POS_HALF) begin
                     stop_en = 1'b1;
                  end else if (sampled == POS_OPEN) begin
                     start_en = 1'b1;
                     start_ccw = 1'b1;
                     start_ticks = cfg.half_from_open_ticks;
                     start_now = MV_HALF;
                  end else if (sampled == POS_CLOSE) begin
                     start_en = 1'b1;
                     start_ticks = cfg.half_from_close_ticks;
                     start_now = MV_HALF;
                  end
               end
               REQ_FULL_CLOSE: begin
                  if (sampled == POS_CLOSE) begin
                     stop_en = 1'b1;
                  end else begin
                     start_en = 1'b1;
                     start_ccw = 1'b1;
                     start_now = MV_FULL_CLOSE;
                  end
               end
               REQ_MAINTAIN: begin
                  start_en = 1'b1;
                  if (sampled == POS_OPEN) begin
                     start_ccw = 1'b1;
                     start_ticks = cfg.half_from_open_ticks;
                     start_now = MV_HALF;
                     start_next = MV_FULL_OPEN;
                  end else if (sampled == POS_CLOSE) begin
                     start_ticks = cfg.half_from_close_ticks;
                     start_now = MV_HALF;
                     start_next = MV_FULL_CLOSE;
                  end else begin
                     start_ccw = 1'b1;
                     start_now = MV_FULL_CLOSE;
                     start_next = MV_HALF;
                  end
               end
               default: stop_en = 1'b1;
            endcase
         end
         CMD_TICK: begin
            // move timer first; expiry chains the queued move or stops
            if (mrun_ff) begin
               if (mcnt_ff <= TICK_W'(1)) begin
                  mrun_in = 1'b0;
                  mcnt_in = '0;
                  unique case (que_ff)
                     MV_FULL_OPEN: begin
                        start_en = 1'b1;
                        start_now = MV_FULL_OPEN;
                     end
                     MV_HALF: begin
                        start_en = 1'b1;
                        start_ticks = cfg.half_from_close_ticks;
                        start_now = MV_HALF;
                     end
                     MV_FULL_CLOSE: begin
                        start_en = 1'b1;
                        start_ccw = 1'b1;
                        start_now = MV_FULL_CLOSE;
                     end
                     default: stop_en = 1'b1;
                  endcase
               end else begin
                  mcnt_in = mcnt_ff - TICK_W'(1);
               end
            end
            // then the guard, unless the expiry already put us to sleep
            if (act_ff && !stop_en) begin
               if (gcnt_ff <= TICK_W'(1)) begin
                  stop_en = 1'b1;
               end else begin
                  gcnt_in = gcnt_ff - TICK_W'(1);
               end
            end
         end
         CMD_OPEN_HIT: begin
            if (que_ff == MV_IDLE && cur_ff == MV_FULL_OPEN) begin
               stop_en = 1'b1;
            end
         end
         CMD_CLOSE_HIT: begin
            if (que_ff == MV_IDLE) begin
               if (cur_ff == MV_FULL_CLOSE) begin
                  stop_en = 1'b1;
               end
            end else if (que_ff == MV_HALF) begin
               start_en = 1'b1;
               start_ticks = cfg.half_from_close_ticks;
               start_now = MV_HALF;
            end
         end
         CMD_OVERCURRENT: begin
            pos_in = POS_OCP;
            stop_en = 1'b1;
         end
         default: ;
      endcase

      // start a timed move
      if (start_en) begin
         on_in = 1'b1;
         ccw_in = start_ccw;
         mcnt_in = start_ticks;
         mrun_in = 1'b1;
         cur_in = start_now;
         que_in = start_next;
      end

      // stop everything and sleep; wins over a start in the same request
      if (stop_en) begin
         mrun_in = 1'b0;
         mcnt_in = '0;
         gcnt_in = '0;
         cur_in = MV_IDLE;
         que_in = MV_IDLE;
         pos_in = sample_pos(pos_in, item.open_limit_n, item.close_limit_n);
         on_in = 1'b0;
         ccw_in = 1'b0;
         act_in = 1'b0;
      end
   end

   assign result.motor_on = on_in;
   assign result.motor_ccw = ccw_in;
   assign result.valve_position = pos_in;
   assign result.awake = act_in;

endmodule

@@ rtl/valve_motor_sequencer.sv @@
// ----------------------------------------------------------------------------
// valve_motor_sequencer
// Valve motor sequencer top level: request register, sequencer core, result
// register and configuration registers.
// ----------------------------------------------------------------------------
// Takes one request per clock while rsp_ready is high and returns one result
// per request, showing motor enable, direction, valve position and awake
// status after that request. A request is captured in the input register;
// when it steps on, the sequencer state and the result register behind rsp_
// update together. The rate is set by the combinational next-state logic of
// the sequencer core; the input register keeps accepting while a result waits,
// so back pressure only reaches req_ready once both registers are full.
// Timing registers are to be written over the csr_ port while no request is
// in flight; the block itself does not enforce this.
module valve_motor_sequencer
   import vms_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_item_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_item_type          rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic         in_valid_ff, in_valid_in;
   req_item_type in_data_ff, in_data_in;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_data_ff, out_data_in;
   logic         step;
   rsp_item_type result;
   cfg_type      cfg;

   // a held request moves on when the result register is free or draining
   assign step = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | step;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in = in_data_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
         in_data_in = req_data;
      end
      out_valid_in = out_valid_ff;
      out_data_in = out_data_ff;
      if (step) begin
         out_valid_in = 1'b1;
         out_data_in = result;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_data_ff;

   vms_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   vms_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_data_ff),
      .cfg    (cfg),
      .result (result)
   );

endmodule

@@ rtl/vms_checker.sv @@
// ----------------------------------------------------------------------------
// vms_checker
// Port-level checks of the valve motor sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vms_checker
   import vms_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_item_type rsp_data
);

   logic seen_ocp_ff;
   logic seen_ocp_in;

   // remember a delivered overcurrent result
   assign seen_ocp_in = seen_ocp_ff |
      (rsp_valid & rsp_ready & (rsp_data.valve_position == POS_OCP));

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ocp_ff <= 1'b0;
      end else begin
         seen_ocp_ff <= seen_ocp_in;
      end
   end

   // a stalled result holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // overcurrent stays until reset
   `ASSERT_IMPLY(a_ocp_sticky, clock, reset, rsp_valid && seen_ocp_ff, rsp_data.valve_position == POS_OCP)

   // a sleeping controller never drives the motor
   `ASSERT_IMPLY(a_sleep_off, clock, reset, rsp_valid && !rsp_data.awake, !rsp_data.motor_on && !rsp_data.motor_ccw)

   // an empty result register never blocks requests
   `ASSERT_IMPLY(a_ready_when_empty, clock, reset, !rsp_valid, req_ready)

endmodule

bind valve_motor_sequencer vms_checker u_vms_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

@@ verif/tb_valve_motor_sequencer.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_valve_motor_sequencer
// Self-checking bench for the valve motor sequencer: directed table rows and
// randomized requests under several timing settings, each status result
// compared against a typed-in status or an in-bench sequencer predictor.
// ----------------------------------------------------------------------------
module tb_valve_motor_sequencer;
   import vms_pkg::*;

   // codes outside the defined kinds and requests
   localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
   localparam logic [2:0] CMD_SPARE_LAST = 3'd7;
   localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
   localparam logic [2:0] REQ_SPARE_LAST = 3'd7;

   localparam logic [TICK_W-1:0] TICKS_MIN = 16'd1;
   localparam logic [TICK_W-1:0] TICKS_MAX = 16'hFFFF;
   localparam int DRAIN_CYCLES = 8;
   localparam int N_RAND_PHASES = 5;
   localparam int PHASE_ITEMS [N_RAND_PHASES] = '{300, 400, 200, 400, 250};
   localparam int OCP_PHASE_ITEMS = 300;

   // directed table row: request, whether the status is typed in, status
   typedef struct packed {
      req_item_type req;
      logic         typed_in;
      rsp_item_type status;
   } table_row_type;

   localparam logic TYPED = 1'b1;
   localparam logic PREDICT = 1'b0;
   localparam rsp_item_type ANY_STATUS = '0;
   localparam int N_ROWS = 27;
   localparam int OCP_ROW = 24;

   // directed table; rows before OCP_ROW are walked with 2/1/3/4 tick timing,
   // rows from OCP_ROW on run last since overcurrent sticks until reset
   localparam table_row_type DIRECTED_ROWS [N_ROWS] = '{
      {CMD_TICK,        REQ_IDLE,       1'b1, 1'b1, TYPED, {1'b0, 1'b0, POS_HALF, 1'b0}},
      {CMD_SPARE_FIRST, REQ_MAINTAIN,   1'b1, 1'b1, TYPED, {1'b0, 1'b0, POS_HALF, 1'b0}},
      {CMD_OPEN_HIT,    REQ_IDLE,       1'b0, 1'b1, TYPED, {1'b0, 1'b0, POS_HALF, 1'b0}},
      {CMD_COMMAND,     REQ_FULL_OPEN,  1'b1, 1'b1, TYPED, {1'b1, 1'b0, POS_HALF, 1'b1}},
      {CMD_OPEN_HIT,    REQ_IDLE,       1'b0, 1'b1, TYPED, {1'b0, 1'b0, POS_OPEN, 1'b0}},
      // maintain from open: half, then chained full open, then stop
      {CMD_COMMAND,     REQ_MAINTAIN,   1'b0, 1'b1, PREDICT, ANY_STATUS},
      {CMD_TICK,        REQ_IDLE,       1'b1, 1'b1, PREDICT, ANY_STATUS},
      {CMD_TICK,        REQ_IDLE,       1'b1, 1'b1, PREDICT, ANY_STATUS},
      {CMD_TICK,        REQ_IDLE,       1'b1, 1'b0, PREDICT, ANY_STATUS},
      // maintain from close, then from half; guard runs out mid-move
      {CMD_COMMAND,     REQ_MAINTAIN,   1'b1, 1'b0, PREDICT, ANY_STATUS},
      {CMD_COMMAND,     REQ_MAINTAIN,   1'b1, 1'b1, PREDICT, ANY_STATUS},
      {CMD_TICK,        REQ_IDLE,       1'b1, 1'b1, PREDICT, ANY_STATUS},
      {CMD_TICK,        REQ_IDLE,       1'b1, 1'b1, PREDICT, ANY_STATUS},
      {CMD_TICK,        REQ_IDLE,       1'b1, 1'b1, PREDICT, ANY_STATUS},
      {CMD_TICK,        REQ_IDLE,       1'b1, 1'b1, PREDICT, ANY_STATUS},
      // close limit with a queued half move starts it
      {CMD_COMMAND,     REQ_MAINTAIN,   1'b1, 1'b1, PREDICT, ANY_STATUS},
      {CMD_CLOSE_HIT,   REQ_IDLE,       1'b1, 1'b0, PREDICT, ANY_STATUS},
      {CMD_COMMAND,     REQ_HALF_OPEN,  1'b1, 1'b1, TYPED, {1'b0, 1'b0, POS_HALF, 1'b0}},
      {CMD_COMMAND,     REQ_HALF_OPEN,  1'b1, 1'b0, PREDICT, ANY_STATUS},
      {CMD_COMMAND,     REQ_FULL_CLOSE, 1'b0, 1'b0, PREDICT, ANY_STATUS},
      {CMD_CLOSE_HIT,   REQ_IDLE,       1'b1, 1'b0, TYPED, {1'b0, 1'b0, POS_CLOSE, 1'b0}},
      {CMD_COMMAND,     REQ_FULL_CLOSE, 1'b1, 1'b0, TYPED, {1'b0, 1'b0, POS_CLOSE, 1'b0}},
      {CMD_COMMAND,     REQ_FULL_OPEN,  1'b1, 1'b1, PREDICT, ANY_STATUS},
      {CMD_COMMAND,     REQ_SPARE_LAST, 1'b1, 1'b1, TYPED, {1'b0, 1'b0, POS_HALF, 1'b0}},
      // overcurrent, then half open only wakes, other moves still run
      {CMD_OVERCURRENT, REQ_IDLE,       1'b0, 1'b0, TYPED, {1'b0, 1'b0, POS_OCP, 1'b0}},
      {CMD_COMMAND,     REQ_HALF_OPEN,  1'b0, 1'b1, TYPED, {1'b0, 1'b0, POS_OCP, 1'b1}},
      {CMD_COMMAND,     REQ_FULL_OPEN,  1'b0, 1'b1, TYPED, {1'b1, 1'b0, POS_OCP, 1'b1}}
   };

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_item_type          req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_item_type          rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   valve_motor_sequencer dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      #4_000_000;
      $error("timed out waiting for requests or results");
      $display("Test completed with failures");
      $finish;
   end

   // predictor state: timing registers and sequencer
   cfg_type           timing;
   pos_type           vlv_pos;
   move_type          cur_move;
   move_type          next_move;
   logic              drv_on;
   logic              drv_ccw;
   logic              move_run;
   logic              ctl_active;
   logic [TICK_W-1:0] move_left;
   logic [TICK_W-1:0] guard_left;

   rsp_item_type status_q [$];
   int           fail_count = 0;
   int           n_checked = 0;
   int           n_directed = 0;
   int           n_random = 0;
   int           n_settings = 0;
   int           burst_left = 0;
   bit           valid_up = 1'b0;
   logic [7:0]   ready_pattern;

   // limit switches set the position unless overcurrent has latched
   task automatic sense_limits(input logic open_n, input logic close_n);
      if (vlv_pos != POS_OCP) begin
         if (!open_n) begin
            vlv_pos = POS_OPEN;
         end else if (!close_n) begin
            vlv_pos = POS_CLOSE;
         end else begin
            vlv_pos = POS_HALF;
         end
      end
   endtask

   task automatic halt_valve(input logic open_n, input logic close_n);
      move_run = 1'b0;
      move_left = '0;
      guard_left = '0;
      cur_move = MV_IDLE;
      next_move = MV_IDLE;
      sense_limits(open_n, close_n);
      drv_on = 1'b0;
      drv_ccw = 1'b0;
      ctl_active = 1'b0;
   endtask

   task automatic run_move(input logic ccw, input logic [TICK_W-1:0] ticks,
                           input move_type now_mv, input move_type then_mv);
      drv_on = 1'b1;
      drv_ccw = ccw;
      move_left = ticks;
      move_run = 1'b1;
      cur_move = now_mv;
      next_move = then_mv;
   endtask

   // advance the sequencer by one request and give the status after it
   task automatic step_sequencer(input req_item_type it, output rsp_item_type st);
      logic on_n;
      logic cn_n;
      on_n = it.open_limit_n;
      cn_n = it.close_limit_n;
      case (it.cmd)
         CMD_COMMAND: begin
            ctl_active = 1'b1;
            guard_left = timing.guard_ticks;
            sense_limits(on_n, cn_n);
            case (it.request)
               REQ_FULL_OPEN: begin
                  if (vlv_pos == POS_OPEN) halt_valve(on_n, cn_n);
                  else run_move(1'b0, timing.full_travel_ticks, MV_FULL_OPEN, MV_IDLE);
               end
               REQ_HALF_OPEN: begin
                  if (vlv_pos == POS_HALF) begin
                     halt_valve(on_n, cn_n);
                  end else if (vlv_pos == POS_OPEN) begin
                     run_move(1'b1, timing.half_from_open_ticks, MV_HALF, MV_IDLE);
                  end else if (vlv_pos == POS_CLOSE) begin
                     run_move(1'b0, timing.half_from_close_ticks, MV_HALF, MV_IDLE);
                  end
               end
               REQ_FULL_CLOSE: begin
                  if (vlv_pos == POS_CLOSE) halt_valve(on_n, cn_n);
                  else run_move(1'b1, timing.full_travel_ticks, MV_FULL_CLOSE, MV_IDLE);
               end
               REQ_MAINTAIN: begin
                  if (vlv_pos == POS_OPEN) begin
                     run_move(1'b1, timing.half_from_open_ticks, MV_HALF, MV_FULL_OPEN);
                  end else if (vlv_pos == POS_CLOSE) begin
                     run_move(1'b0, timing.half_from_close_ticks, MV_HALF, MV_FULL_CLOSE);
                  end else begin
                     run_move(1'b1, timing.full_travel_ticks, MV_FULL_CLOSE, MV_HALF);
                  end
               end
               default: halt_valve(on_n, cn_n);
            endcase
         end
         CMD_TICK: begin
            // move timer first; on expiry run the chained move or stop
            if (move_run) begin
               if (move_left <= 16'd1) begin
                  move_run = 1'b0;
                  move_left = '0;
                  case (next_move)
                     MV_FULL_OPEN:
                        run_move(1'b0, timing.full_travel_ticks, MV_FULL_OPEN, MV_IDLE);
                     MV_HALF:
                        run_move(1'b0, timing.half_from_close_ticks, MV_HALF, MV_IDLE);
                     MV_FULL_CLOSE:
                        run_move(1'b1, timing.full_travel_ticks, MV_FULL_CLOSE, MV_IDLE);
                     default: halt_valve(on_n, cn_n);
                  endcase
               end else begin
                  move_left = move_left - 16'd1;
               end
            end
            // then the guard timer
            if (ctl_active) begin
               if (guard_left <= 16'd1) halt_valve(on_n, cn_n);
               else guard_left = guard_left - 16'd1;
            end
         end
         CMD_OPEN_HIT: begin
            if (next_move == MV_IDLE && cur_move == MV_FULL_OPEN) halt_valve(on_n, cn_n);
         end
         CMD_CLOSE_HIT: begin
            if (next_move == MV_IDLE) begin
               if (cur_move == MV_FULL_CLOSE) halt_valve(on_n, cn_n);
            end else if (next_move == MV_HALF) begin
               run_move(1'b0, timing.half_from_close_ticks, MV_HALF, MV_IDLE);
            end
         end
         CMD_OVERCURRENT: begin
            vlv_pos = POS_OCP;
            halt_valve(on_n, cn_n);
         end
         default: ;
      endcase
      st.motor_on = drv_on;
      st.motor_ccw = drv_ccw;
      st.valve_position = vlv_pos;
      st.awake = ctl_active;
   endtask

   // one APB write; the idle cycle after keeps back-to-back writes apart
   task automatic write_timing(input reg_idx_type idx, input logic [TICK_W-1:0] ticks);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {{(CSR_DATA_W - TICK_W){1'b0}}, ticks};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_FULL_TRAVEL: timing.full_travel_ticks = ticks;
         REG_HALF_OPEN:   timing.half_from_open_ticks = ticks;
         REG_HALF_CLOSE:  timing.half_from_close_ticks = ticks;
         REG_GUARD:       timing.guard_ticks = ticks;
      endcase
   endtask

   task automatic apply_timing(input cfg_type setting);
      write_timing(REG_FULL_TRAVEL, setting.full_travel_ticks);
      write_timing(REG_HALF_OPEN, setting.half_from_open_ticks);
      write_timing(REG_HALF_CLOSE, setting.half_from_close_ticks);
      write_timing(REG_GUARD, setting.guard_ticks);
      n_settings++;
   endtask

   task automatic lower_valid();
      if (valid_up) begin
         req_valid <= 1'b0;
         valid_up = 1'b0;
      end
   endtask

   // drive one request, predict its status once it is taken
   task automatic send_request(input req_item_type it, input logic use_typed,
                               input rsp_item_type typed_st);
      rsp_item_type st;
      req_valid <= 1'b1;
      req_data <= it;
      valid_up = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      step_sequencer(it, st);
      status_q.push_back(use_typed ? typed_st : st);
   endtask

   // bursts of random length with random gaps, some bursts back to back
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            lower_valid();
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_for_results();
      lower_valid();
      do @(posedge clock); while (status_q.size() != 0);
   endtask

   task automatic walk_table(input int first, input int last);
      for (int i = first; i <= last; i++) begin
         send_request(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].typed_in,
                      DIRECTED_ROWS[i].status);
         pace_sender();
         n_directed++;
      end
   endtask

   // mostly commands and ticks with limit levels near a real valve
   function automatic req_item_type random_request(input bit allow_ocp);
      req_item_type it;
      int pick;
      int lim;
      int sel;
      pick = $urandom_range(0, 99);
      lim = $urandom_range(0, 9);
      it.request = 3'($urandom_range(0, 7));
      it.open_limit_n = !(lim <= 2 || lim == 9);
      it.close_limit_n = !((lim >= 3 && lim <= 5) || lim == 9);
      if (pick < 22) begin
         it.cmd = CMD_COMMAND;
         sel = $urandom_range(0, 15);
         if (sel < 12) begin
            case (sel % 4)
               0: it.request = REQ_FULL_OPEN;
               1: it.request = REQ_HALF_OPEN;
               2: it.request = REQ_FULL_CLOSE;
               default: it.request = REQ_MAINTAIN;
            endcase
         end else if (sel < 14) begin
            it.request = REQ_IDLE;
         end else begin
            it.request = 3'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
         end
      end else if (pick < 72) begin
         it.cmd = CMD_TICK;
      end else if (pick < 80) begin
         it.cmd = CMD_OPEN_HIT;
      end else if (pick < 88) begin
         it.cmd = CMD_CLOSE_HIT;
      end else if (pick < 92) begin
         it.cmd = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
      end else if (allow_ocp && pick < 94) begin
         it.cmd = CMD_OVERCURRENT;
      end else begin
         it.cmd = CMD_TICK;
      end
      return it;
   endfunction

   // ignored kinds do not count; halfway through, wait for all results
   task automatic run_random(input int target, input bit allow_ocp);
      req_item_type it;
      int counted;
      bit paused;
      counted = 0;
      paused = 1'b0;
      while (counted < target) begin
         it = random_request(allow_ocp);
         send_request(it, PREDICT, ANY_STATUS);
         n_random++;
         if (it.cmd < CMD_SPARE_FIRST) counted++;
         if (!paused && counted >= target / 2) begin
            paused = 1'b1;
            wait_for_results();
         end
         pace_sender();
      end
   endtask

   // receiver stall pattern: open, random, one in four, periodic blocks
   always @(posedge clock) begin
      if (reset) begin
         ready_pattern <= '0;
         rsp_ready <= 1'b0;
      end else begin
         ready_pattern <= ready_pattern + 8'd1;
         case (ready_pattern[7:6])
            2'd0: rsp_ready <= 1'b1;
            2'd1: rsp_ready <= 1'($urandom_range(0, 1));
            2'd2: rsp_ready <= (ready_pattern[1:0] == 2'd0);
            default: rsp_ready <= (ready_pattern[3:0] < 4'd8 || ready_pattern[3:0] > 4'd13);
         endcase
      end
   end

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   // compare each status result with the oldest prediction
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (status_q.size() == 0) begin
            $error("status result with no request outstanding: %b", rsp_data);
            fail_count++;
         end else begin
            want = status_q.pop_front();
            check_field("motor_on", want.motor_on, rsp_data.motor_on);
            check_field("motor_ccw", want.motor_ccw, rsp_data.motor_ccw);
            check_field("valve_position", want.valve_position, rsp_data.valve_position);
            check_field("awake", want.awake, rsp_data.awake);
            n_checked++;
         end
      end
   end

   initial begin
      cfg_type setting;
      timing = {FULL_TRAVEL_RST, HALF_OPEN_RST, HALF_CLOSE_RST, GUARD_RST};
      vlv_pos = POS_HALF;
      cur_move = MV_IDLE;
      next_move = MV_IDLE;
      drv_on = 1'b0;
      drv_ccw = 1'b0;
      move_run = 1'b0;
      ctl_active = 1'b0;
      move_left = '0;
      guard_left = '0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part with short travel times so timeouts show up
      apply_timing({16'd2, 16'd1, 16'd3, 16'd4});
      walk_table(0, OCP_ROW - 1);

      // random phases: minimum, small, maximum, short guard, moderate
      for (int phase = 0; phase < N_RAND_PHASES; phase++) begin
         case (phase)
            0: setting = {TICKS_MIN, TICKS_MIN, TICKS_MIN, TICKS_MIN};
            1: setting = {TICK_W'($urandom_range(1, 12)), TICK_W'($urandom_range(1, 8)),
                          TICK_W'($urandom_range(1, 8)), TICK_W'($urandom_range(1, 30))};
            2: setting = {TICKS_MAX, TICKS_MAX, TICKS_MAX, TICKS_MAX};
            3: setting = {TICK_W'($urandom_range(5, 20)), TICK_W'($urandom_range(3, 10)),
                          TICK_W'($urandom_range(3, 10)), TICK_W'($urandom_range(2, 12))};
            default: setting = {TICK_W'($urandom_range(1, 100)), TICK_W'($urandom_range(1, 100)),
                                TICK_W'($urandom_range(1, 100)), TICK_W'($urandom_range(1, 100))};
         endcase
         wait_for_results();
         apply_timing(setting);
         run_random(PHASE_ITEMS[phase], 1'b0);
      end

      // overcurrent rows, then random traffic with the status latched
      walk_table(OCP_ROW, N_ROWS - 1);
      wait_for_results();
      apply_timing({TICK_W'($urandom_range(1, 8)), TICK_W'($urandom_range(1, 6)),
                    TICK_W'($urandom_range(1, 6)), TICK_W'($urandom_range(2, 20))});
      run_random(OCP_PHASE_ITEMS, 1'b1);

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d table and %0d random requests over %0d timing settings,",
               n_directed, n_random, n_settings);
      $display("overcurrent last; %0d status results compared, %0d field mismatches.",
               n_checked, fail_count);
      if (fail_count == 0 && status_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/vms_pkg.sv
rtl/vms_csr.sv
rtl/vms_core.sv
rtl/valve_motor_sequencer.sv
rtl/vms_checker.sv
verif/tb_valve_motor_sequencer.sv
